@@ hdl/vtu_pkg.sv @@
// Shared types and constants for the vertex transform unit.
// Depends on nothing; every other file of the block imports it.
package vtu_pkg;

   localparam int FIELD_W         = 32;
   localparam int OP_W            = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 3;
   localparam int HALF_W          = 32;
   localparam int DEF_DATA_WIDTH  = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [OP_W-1:0] {
      OP_VEC4  = 2'd0,
      OP_POINT = 2'd1,
      OP_DIR   = 2'd2
   } op_type;

   // point: divide by transformed w; vec4: keep transformed w on the output
   typedef struct packed {
      logic point;
      logic vec4;
   } vtu_mode_type;

endpackage

@@ hdl/vtu_front.sv @@
// Front end: accepts request transactions, decodes the operation and builds the vec4.
// Depends on vtu_pkg.
module vtu_front #(
   parameter int DW = 32,
   parameter int FB = 16,
   parameter int VW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [vtu_pkg::OP_W-1:0]      req_operation,
   input  logic [vtu_pkg::FIELD_W-1:0]   req_in_x,
   input  logic [vtu_pkg::FIELD_W-1:0]   req_in_y,
   input  logic [vtu_pkg::FIELD_W-1:0]   req_in_z,
   input  logic [vtu_pkg::FIELD_W-1:0]   req_in_w,
   input  logic                          q_ready,
   output logic                          q_push,
   output vtu_pkg::vtu_mode_type         q_mode,
   output logic [3:0][VW-1:0]            q_vec
);
   import vtu_pkg::*;

   logic               f_valid_ff, f_valid_in;
   vtu_mode_type       f_mode_ff, f_mode_in;
   logic [3:0][VW-1:0] f_vec_ff, f_vec_in;
   logic               accept;

   assign req_stall = f_valid_ff && !q_ready;
   assign q_push    = f_valid_ff && q_ready;
   assign accept    = req_valid && !req_stall;
   assign q_mode    = f_mode_ff;
   assign q_vec     = f_vec_ff;

   always_comb begin
      f_vec_in[0] = VW'($signed(req_in_x[DW-1:0]));
      f_vec_in[1] = VW'($signed(req_in_y[DW-1:0]));
      f_vec_in[2] = VW'($signed(req_in_z[DW-1:0]));
      unique case (op_type'(req_operation))
         OP_POINT: begin
            f_mode_in   = '{point: 1'b1, vec4: 1'b0};
            f_vec_in[3] = VW'(1) << FB;
         end
         OP_DIR: begin
            f_mode_in   = '{point: 1'b0, vec4: 1'b0};
            f_vec_in[3] = '0;
         end
         default: begin
            // full vec4, also the unused code
            f_mode_in   = '{point: 1'b0, vec4: 1'b1};
            f_vec_in[3] = VW'($signed(req_in_w[DW-1:0]));
         end
      endcase
      if (accept) begin
         f_valid_in = 1'b1;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (accept) begin
         f_mode_ff <= f_mode_in;
         f_vec_ff  <= f_vec_in;
      end
   end

endmodule

@@ hdl/vtu_queue.sv @@
// Short queue between the front end and the arithmetic back end.
// Depends on vtu_pkg.
module vtu_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             ready,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   import vtu_pkg::*;

   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;

   assign ready     = count_ff != CNW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(DEPTH))
      else $error("queue holds more entries than its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

@@ hdl/vtu_back.sv @@
// Back end: matrix-vector product, saturation and pipelined point divide.
// Depends on vtu_pkg.
module vtu_back #(
   parameter int DW = 32,
   parameter int FB = 16,
   parameter int VW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [3:0][3:0][DW-1:0]       coef,
   input  logic                          q_valid,
   input  vtu_pkg::vtu_mode_type         q_mode,
   input  logic [3:0][VW-1:0]            q_vec,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [vtu_pkg::FIELD_W-1:0]   rsp_out_x,
   output logic [vtu_pkg::FIELD_W-1:0]   rsp_out_y,
   output logic [vtu_pkg::FIELD_W-1:0]   rsp_out_z,
   output logic [vtu_pkg::FIELD_W-1:0]   rsp_out_w,
   output logic                          rsp_saturated
);
   import vtu_pkg::*;

   localparam int CW = DW + VW;
   localparam int SW = CW + 2;
   localparam int NB = DW + FB;

   typedef struct packed {
      logic               do_div;
      logic [2:0]         neg;
      logic [2:0][DW-1:0] res;
      logic [DW-1:0]      out_w;
      logic [DW-1:0]      dvs;
      logic               sat;
   } side_type;

   logic adv;

   // stage 1: products
   logic                        s1_valid_ff;
   vtu_mode_type                s1_mode_ff;
   logic signed [CW-1:0]        s1_prod_ff [4][4];
   logic signed [CW-1:0]        s1_prod_in [4][4];
   // stage 2: pair sums
   logic                        s2_valid_ff;
   vtu_mode_type                s2_mode_ff;
   logic signed [CW:0]          s2_pair_ff [4][2];
   logic signed [CW:0]          s2_pair_in [4][2];
   // stage 3: row sums, scaled and clamped
   logic                        s3_valid_ff;
   vtu_mode_type                s3_mode_ff;
   logic [3:0][DW-1:0]          s3_res_ff, s3_res_in;
   logic                        s3_sat_ff, s3_sat_in;
   logic signed [SW-1:0]        row_sum [4];
   logic signed [SW-1:0]        row_sh [4];
   logic [SW-DW:0]              row_top [4];
   // divide pipeline, index 0 is the prepared operand stage
   logic                        dv_valid_ff [NB+1];
   side_type                    dv_side_ff [NB+1];
   side_type                    dv_side_in [NB+1];
   logic [2:0][DW-1:0]          dv_rem_ff [NB+1];
   logic [2:0][DW-1:0]          dv_rem_in [NB+1];
   logic [2:0][NB-1:0]          dv_nq_ff [NB+1];
   logic [2:0][NB-1:0]          dv_nq_in [NB+1];
   logic [2:0][DW:0]            trial [NB+1];
   logic [2:0]                  ge [NB+1];
   logic [2:0][DW-1:0]          abs_res;
   logic [DW-1:0]               w_val;
   // output stage
   logic                        out_valid_ff;
   logic [3:0][DW-1:0]          out_res_ff, out_res_in;
   logic                        out_sat_ff, out_sat_in;
   logic [2:0][NB:0]            q_signed;
   logic [2:0][NB-DW+1:0]       q_top;
   logic [2:0]                  q_clamp;

   assign adv   = !out_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            s1_prod_in[r][c] = CW'($signed(coef[c][r])) * CW'($signed(q_vec[c]));
         end
      end
      for (int r = 0; r < 4; r++) begin
         s2_pair_in[r][0] = (CW+1)'(s1_prod_ff[r][0]) + (CW+1)'(s1_prod_ff[r][1]);
         s2_pair_in[r][1] = (CW+1)'(s1_prod_ff[r][2]) + (CW+1)'(s1_prod_ff[r][3]);
      end
      s3_sat_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         row_sum[r] = SW'(s2_pair_ff[r][0]) + SW'(s2_pair_ff[r][1]);
         row_sh[r]  = row_sum[r] >>> FB;
         row_top[r] = row_sh[r][SW-1:DW-1];
         if ((&row_top[r]) || !(|row_top[r])) begin
            s3_res_in[r] = row_sh[r][DW-1:0];
         end else begin
            s3_res_in[r] = {row_sh[r][SW-1], {(DW-1){!row_sh[r][SW-1]}}};
            s3_sat_in    = 1'b1;
         end
      end
   end

   // operand preparation: magnitudes and signs for the divide
   always_comb begin
      w_val = s3_res_ff[3];
      dv_side_in[0].do_div = s3_mode_ff.point && (w_val != '0);
      dv_side_in[0].out_w  = s3_mode_ff.vec4 ? w_val : '0;
      dv_side_in[0].dvs    = w_val[DW-1] ? (~w_val + DW'(1)) : w_val;
      dv_side_in[0].sat    = s3_sat_ff;
      for (int l = 0; l < 3; l++) begin
         abs_res[l] = s3_res_ff[l][DW-1] ? (~s3_res_ff[l] + DW'(1)) : s3_res_ff[l];
         dv_side_in[0].res[l] = s3_res_ff[l];
         dv_side_in[0].neg[l] = s3_res_ff[l][DW-1] ^ w_val[DW-1];
         dv_rem_in[0][l]      = '0;
         dv_nq_in[0][l]       = {abs_res[l], {FB{1'b0}}};
         trial[0][l]          = '0;
         ge[0][l]             = 1'b0;
      end
      // one quotient bit per stage, restoring
      for (int k = 1; k <= NB; k++) begin
         dv_side_in[k] = dv_side_ff[k-1];
         for (int l = 0; l < 3; l++) begin
            trial[k][l]  = {dv_rem_ff[k-1][l], dv_nq_ff[k-1][l][NB-1]};
            ge[k][l]     = trial[k][l] >= {1'b0, dv_side_ff[k-1].dvs};
            dv_rem_in[k][l] = ge[k][l] ? DW'(trial[k][l] - {1'b0, dv_side_ff[k-1].dvs})
                                       : trial[k][l][DW-1:0];
            dv_nq_in[k][l]  = {dv_nq_ff[k-1][l][NB-2:0], ge[k][l]};
         end
      end
   end

   // sign and clamp of the quotients
   always_comb begin
      out_sat_in = dv_side_ff[NB].sat;
      for (int l = 0; l < 3; l++) begin
         q_signed[l] = dv_side_ff[NB].neg[l] ? ((NB+1)'(0) - {1'b0, dv_nq_ff[NB][l]})
                                             : {1'b0, dv_nq_ff[NB][l]};
         q_top[l]    = q_signed[l][NB:DW-1];
         q_clamp[l]  = !((&q_top[l]) || !(|q_top[l]));
         if (!dv_side_ff[NB].do_div) begin
            out_res_in[l] = dv_side_ff[NB].res[l];
         end else if (q_clamp[l]) begin
            out_res_in[l] = {q_signed[l][NB], {(DW-1){!q_signed[l][NB]}}};
            out_sat_in    = 1'b1;
         end else begin
            out_res_in[l] = q_signed[l][DW-1:0];
         end
      end
      out_res_in[3] = dv_side_ff[NB].out_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= NB; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_valid_ff    <= q_valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         dv_valid_ff[0] <= s3_valid_ff;
         for (int k = 1; k <= NB; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         out_valid_ff   <= dv_valid_ff[NB];
      end
      if (adv) begin
         s1_mode_ff <= q_mode;
         s1_prod_ff <= s1_prod_in;
         s2_mode_ff <= s1_mode_ff;
         s2_pair_ff <= s2_pair_in;
         s3_mode_ff <= s2_mode_ff;
         s3_res_ff  <= s3_res_in;
         s3_sat_ff  <= s3_sat_in;
         for (int k = 0; k <= NB; k++) begin
            dv_side_ff[k] <= dv_side_in[k];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_nq_ff[k]   <= dv_nq_in[k];
         end
         out_res_ff <= out_res_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = FIELD_W'($signed(out_res_ff[0]));
   assign rsp_out_y     = FIELD_W'($signed(out_res_ff[1]));
   assign rsp_out_z     = FIELD_W'($signed(out_res_ff[2]));
   assign rsp_out_w     = FIELD_W'($signed(out_res_ff[3]));
   assign rsp_saturated = out_sat_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(dv_valid_ff[NB]) && $stable(s1_valid_ff))
      else $error("pipeline advanced while the result was stalled");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while the pipeline was held");

endmodule

@@ hdl/vertex_transform_unit.sv @@
// Top level of the vertex transform unit: coefficient registers plus front, queue, back.
// Depends on vtu_pkg, vtu_front, vtu_queue and vtu_back.
//
// Usage:
//  - Request channel (req_*): one vertex per transaction with an operation code
//    (full vec4, point with perspective divide, direction). Accepted on a rising
//    edge with req_valid high and req_stall low.
//  - Result channel (rsp_*): one transaction per request, in order, carrying the
//    transformed x, y, z, w and a saturation flag. Taken when rsp_valid is high
//    and rsp_stall is low.
//  - Coefficient port (csr_*): eight 64-bit registers, two signed coefficients
//    each, column-major. Write only while the unit is idle.
//  - Throughput: one transaction per cycle, sustained, whatever the operation, while rsp_stall is low.
//  - Path: front register, queue, product, pair-sum, row-sum and operand stages,
//    divide stages, output register; the point divide resolves one quotient bit per stage.
//  - Reset clears all valid state and loads the identity matrix.
//  - A stalled result holds the whole back end; the queue then fills, and
//    req_stall rises once the queue and the front register are both full.
module vertex_transform_unit #(
   parameter int DATA_WIDTH = vtu_pkg::DEF_DATA_WIDTH,
   parameter int FRAC_BITS  = vtu_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [vtu_pkg::OP_W-1:0]          req_operation,
   input  logic [vtu_pkg::FIELD_W-1:0]       req_in_x,
   input  logic [vtu_pkg::FIELD_W-1:0]       req_in_y,
   input  logic [vtu_pkg::FIELD_W-1:0]       req_in_z,
   input  logic [vtu_pkg::FIELD_W-1:0]       req_in_w,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vtu_pkg::FIELD_W-1:0]       rsp_out_x,
   output logic [vtu_pkg::FIELD_W-1:0]       rsp_out_y,
   output logic [vtu_pkg::FIELD_W-1:0]       rsp_out_z,
   output logic [vtu_pkg::FIELD_W-1:0]       rsp_out_w,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [vtu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vtu_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import vtu_pkg::*;

   // vector lanes must also hold 1.0 for the point-mode w
   localparam int VEC_W = (FRAC_BITS + 2 > DATA_WIDTH) ? FRAC_BITS + 2 : DATA_WIDTH;
   localparam int MODE_W = $bits(vtu_mode_type);
   localparam int Q_W = MODE_W + 4 * VEC_W;
   localparam logic [DATA_WIDTH-1:0] FX_ONE = DATA_WIDTH'(1) << FRAC_BITS;

   // coefficients indexed [column][row]
   logic [3:0][3:0][DATA_WIDTH-1:0] coef_ff, coef_in;

   logic                    q_ready, q_push, q_pop, q_not_empty;
   vtu_mode_type            f_mode, b_mode;
   logic [3:0][VEC_W-1:0]   f_vec, b_vec;
   logic [Q_W-1:0]          q_out;

   // Decode a register write into its column and row pair
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         coef_in[csr_index[2:1]][{csr_index[0], 1'b0}] = csr_wr_data[DATA_WIDTH-1:0];
         coef_in[csr_index[2:1]][{csr_index[0], 1'b1}] =
            csr_wr_data[HALF_W+DATA_WIDTH-1:HALF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               coef_ff[c][r] <= (c == r) ? FX_ONE : '0;
            end
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Front: accept and decode each transaction
   vtu_front #(
      .DW (DATA_WIDTH),
      .FB (FRAC_BITS),
      .VW (VEC_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_in_x      (req_in_x),
      .req_in_y      (req_in_y),
      .req_in_z      (req_in_z),
      .req_in_w      (req_in_w),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_mode        (f_mode),
      .q_vec         (f_vec)
   );

   // Queue: decouple the front from the back-end stall
   vtu_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_mode, f_vec}),
      .ready     (q_ready),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   assign b_mode = vtu_mode_type'(q_out[Q_W-1 -: MODE_W]);
   assign b_vec  = q_out[4*VEC_W-1:0];

   // Back: multiply, reduce, saturate, divide
   vtu_back #(
      .DW (DATA_WIDTH),
      .FB (FRAC_BITS),
      .VW (VEC_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .coef          (coef_ff),
      .q_valid       (q_not_empty),
      .q_mode        (b_mode),
      .q_vec         (b_vec),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_saturated (rsp_saturated)
   );

endmodule
